FILE: hdl/swfd_pkg.sv
// ---------------------------------------------------------------------------
// swfd_pkg
// Types and constants shared by the single-wire sensor frame decoder.
// ---------------------------------------------------------------------------
package swfd_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic       OP_START              = 1'b0;
  localparam logic [7:0] FIRST_DATA_TRANSITION = 8'd4;

  localparam logic [7:0] TIMEOUT_COUNT_RESET     = 8'd255;
  localparam logic [7:0] ONE_BIT_THRESHOLD_RESET = 8'd40;
  localparam logic [7:0] MAX_TRANSITIONS_RESET   = 8'd85;

  typedef enum logic [1:0] {
    REG_TIMEOUT_COUNT     = 2'd0,
    REG_ONE_BIT_THRESHOLD = 2'd1,
    REG_MAX_TRANSITIONS   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic op;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] humidity_whole;
    logic [7:0] humidity_fraction;
    logic [7:0] temperature_whole;
    logic [7:0] temperature_fraction;
    logic [7:0] check_byte;
    logic       sum_ok;
    logic [5:0] bits_received;
    logic       timed_out;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      level;
  } cmd_t;

  typedef struct packed {
    logic [7:0] timeout_count;
    logic [7:0] one_bit_threshold;
    logic [7:0] max_transitions;
  } cfg_t;

endpackage

FILE: hdl/swfd_front.sv
// ---------------------------------------------------------------------------
// swfd_front
// Accepts input transfers, classifies them as start or sample commands and
// holds them in a short queue for the decode stage.
// ---------------------------------------------------------------------------
module swfd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  swfd_pkg::in_item_t in_data,
  output logic               cmd_valid,
  output swfd_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);

  localparam int PtrW = (swfd_pkg::QUEUE_DEPTH > 1) ? $clog2(swfd_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(swfd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(swfd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(swfd_pkg::QUEUE_DEPTH);

  swfd_pkg::cmd_t  queue [swfd_pkg::QUEUE_DEPTH];
  swfd_pkg::cmd_t  cmd_in;
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  always_comb begin
    cmd_in.kind  = (in_data.op == swfd_pkg::OP_START) ? swfd_pkg::CMD_START
                                                       : swfd_pkg::CMD_SAMPLE;
    cmd_in.level = in_data.pin_level;
  end

  assign in_stall  = (count == FullCnt);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/swfd_back.sv
// ---------------------------------------------------------------------------
// swfd_back
// Runs the pulse-width decode on queued commands and registers the frame
// result until the output transfer completes.
// ---------------------------------------------------------------------------
module swfd_back #(
  parameter int FRAME_BYTES = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  swfd_pkg::cfg_t      cfg,
  input  logic                cmd_valid,
  input  swfd_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output swfd_pkg::out_item_t out_data
);

  localparam int TotalBitsInt = FRAME_BYTES * swfd_pkg::BYTE_BITS;
  localparam int BW           = $clog2(TotalBitsInt + 1);
  localparam int SelW         = BW - $clog2(swfd_pkg::BYTE_BITS);
  localparam int DataBytes    = (FRAME_BYTES - 1 < 4) ? FRAME_BYTES - 1 : 4;
  localparam logic [BW-1:0] TotalBits = BW'(TotalBitsInt);

  logic [7:0]    frame_bytes [FRAME_BYTES];
  logic          previous_level;
  logic [7:0]    run_length;
  logic [7:0]    transition_index;
  logic [BW-1:0] bit_index;
  logic          frame_active;

  logic [7:0]    bytes_next [FRAME_BYTES];
  logic [BW-1:0] bit_index_next;
  logic [7:0]    run_inc;
  logic [7:0]    trans_next;
  logic [SelW-1:0] byte_sel;
  logic          do_start;
  logic          do_sample;
  logic          same_level;
  logic          data_edge;
  logic          bit_val;
  logic          timeout_hit;
  logic          limit_hit;
  logic          finish;
  logic          slot_free;
  logic          consume;
  logic [7:0]    sum;
  logic [7:0]    low_bytes [4];
  swfd_pkg::out_item_t result;

  always_comb begin
    do_start    = (cmd.kind == swfd_pkg::CMD_START);
    do_sample   = (cmd.kind == swfd_pkg::CMD_SAMPLE) && frame_active;
    same_level  = (cmd.level == previous_level);
    run_inc     = run_length + 8'd1;
    trans_next  = transition_index + 8'd1;
    byte_sel    = bit_index[BW-1:BW-SelW];
    data_edge   = (transition_index >= swfd_pkg::FIRST_DATA_TRANSITION) &&
                  !transition_index[0] && (bit_index < TotalBits);
    bit_val     = (run_length > cfg.one_bit_threshold);
    timeout_hit = do_sample && same_level && (run_inc == cfg.timeout_count);
    limit_hit   = do_sample && !same_level && (trans_next >= cfg.max_transitions);
    finish      = timeout_hit || limit_hit;
    slot_free   = !out_valid || !out_stall;
    consume     = cmd_valid && (!finish || slot_free);

    bit_index_next = bit_index;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      bytes_next[k] = frame_bytes[k];
      if (do_sample && !same_level && data_edge && (int'(byte_sel) == k)) begin
        bytes_next[k] = {frame_bytes[k][6:0], bit_val};
      end
    end
    if (do_sample && !same_level && data_edge) begin
      bit_index_next = bit_index + 1'b1;
    end

    sum = '0;
    for (int k = 0; k < FRAME_BYTES - 1; k++) begin
      sum = sum + bytes_next[k];
    end
    for (int k = 0; k < 4; k++) begin
      low_bytes[k] = '0;
    end
    for (int k = 0; k < DataBytes; k++) begin
      low_bytes[k] = bytes_next[k];
    end

    result.humidity_whole       = low_bytes[0];
    result.humidity_fraction    = low_bytes[1];
    result.temperature_whole    = low_bytes[2];
    result.temperature_fraction = low_bytes[3];
    result.check_byte           = bytes_next[FRAME_BYTES-1];
    result.sum_ok               = (sum == bytes_next[FRAME_BYTES-1]);
    result.bits_received        = 6'(bit_index_next);
    result.timed_out            = timeout_hit;
  end

  assign cmd_pop = consume;

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level   <= 1'b1;
      run_length       <= '0;
      transition_index <= '0;
      bit_index        <= '0;
      frame_active     <= 1'b0;
      for (int k = 0; k < FRAME_BYTES; k++) begin
        frame_bytes[k] <= '0;
      end
    end else if (consume) begin
      if (do_start) begin
        previous_level   <= 1'b1;
        run_length       <= '0;
        transition_index <= '0;
        bit_index        <= '0;
        frame_active     <= 1'b1;
        for (int k = 0; k < FRAME_BYTES; k++) begin
          frame_bytes[k] <= '0;
        end
      end else if (do_sample) begin
        if (same_level) begin
          run_length <= run_inc;
        end else begin
          previous_level   <= cmd.level;
          run_length       <= '0;
          transition_index <= trans_next;
          bit_index        <= bit_index_next;
          for (int k = 0; k < FRAME_BYTES; k++) begin
            frame_bytes[k] <= bytes_next[k];
          end
        end
        if (finish) begin
          frame_active <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && finish) begin
      out_data <= result;
    end
  end

endmodule

FILE: hdl/single_wire_sensor_frame_decoder_core.sv
// ---------------------------------------------------------------------------
// single_wire_sensor_frame_decoder_core
// Decodes pulse-width coded frames from a single-wire humidity and
// temperature sensor, one pin sample per input transfer.
// ---------------------------------------------------------------------------
// The block takes one input transfer every clock while in_stall is low: a
// start command or one sample of the data pin. Transfers enter a two-entry
// command queue and the decode stage retires one command per clock, so a
// sample is decoded once it reaches the queue head and a frame result is
// valid on the cycle after that. A result sits in the output register until
// its transfer completes; the decode stage only waits when the command that
// ends a frame finds that register still full, and in_stall rises once the
// queue fills behind it. Registers are written through cfg_write, cfg_index
// and cfg_data, with no read-back; indexes past the last register are ignored.
module single_wire_sensor_frame_decoder_core #(
  parameter int FRAME_BYTES = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  swfd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output swfd_pkg::out_item_t out_data,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  swfd_pkg::cfg_t cfg;
  logic           cmd_valid;
  swfd_pkg::cmd_t cmd;
  logic           cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_count     <= swfd_pkg::TIMEOUT_COUNT_RESET;
      cfg.one_bit_threshold <= swfd_pkg::ONE_BIT_THRESHOLD_RESET;
      cfg.max_transitions   <= swfd_pkg::MAX_TRANSITIONS_RESET;
    end else if (cfg_write) begin
      case (swfd_pkg::cfg_reg_t'(cfg_index))
        swfd_pkg::REG_TIMEOUT_COUNT:     cfg.timeout_count     <= cfg_data;
        swfd_pkg::REG_ONE_BIT_THRESHOLD: cfg.one_bit_threshold <= cfg_data;
        swfd_pkg::REG_MAX_TRANSITIONS:   cfg.max_transitions   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  swfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  swfd_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/swfd_checker.sv
// ---------------------------------------------------------------------------
// swfd_checker
// Port-level checks for the frame decoder, bound to the top level.
// ---------------------------------------------------------------------------
module swfd_checker #(
  parameter int FRAME_BYTES = 5
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input swfd_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input swfd_pkg::out_item_t out_data
);

  localparam int TotalBits = FRAME_BYTES * swfd_pkg::BYTE_BITS;

  // hold a stalled input transfer
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed or dropped");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  a_bit_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (TotalBits < 64) |-> (int'(out_data.bits_received) <= TotalBits))
    else $error("bit count past frame length");

  a_checksum: assert property (@(posedge clk) disable iff (rst)
    out_valid && (FRAME_BYTES == 5) |->
      out_data.sum_ok == (8'(out_data.humidity_whole + out_data.humidity_fraction +
                             out_data.temperature_whole + out_data.temperature_fraction)
                          == out_data.check_byte))
    else $error("checksum flag disagrees with bytes");

endmodule

bind single_wire_sensor_frame_decoder_core swfd_checker #(
  .FRAME_BYTES (FRAME_BYTES)
) u_swfd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
